[rtl/core/btbm_pkg.sv]
`timescale 1ns / 1ps
// Package: shared types, constants and tables of the back-to-back track pair matcher.
package btbm_pkg;

	localparam int DEFAULT_MAX_TRACKS = 64;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_W = 36;
	localparam int ANGLE_Z_W = 18;
	localparam logic [15:0] INV_GAIN = 16'd39797;
	localparam logic [17:0] P_MAX = 18'd262143;
	localparam int ROOT_STEPS = 20;
	localparam int ROOT_W = 40;
	localparam int INDEX_W = 6;
	localparam logic [5:0] MAX_RESULTS = 6'd63;

	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_MIN_HITS     = 3'd0,
		REG_ANGLE_WINDOW = 3'd1,
		REG_X_WINDOW     = 3'd2,
		REG_Y_WINDOW     = 3'd3,
		REG_Z_WINDOW     = 3'd4
	} reg_index_t;

	localparam logic [7:0]  MIN_HITS_RST     = 8'd20;
	localparam logic [15:0] ANGLE_WINDOW_RST = 16'd313;
	localparam logic [15:0] X_WINDOW_RST     = 16'd32;
	localparam logic [15:0] Y_WINDOW_RST     = 16'd32;
	localparam logic [15:0] Z_WINDOW_RST     = 16'd64;

	// One stored track as it travels around the ring of cells.
	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [15:0] z;
		logic [15:0]        dir;
		logic [17:0]        p;
		logic               qual;
	} track_t;

	// Handshake between the top level and an iterative unit.
	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
	} unit_sts_t;

	// Arctangent of 2^-i in 1/65536 of a turn.
	function automatic logic [13:0] atan_turn(input logic [3:0] i);
		logic [13:0] v;
		case (i)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			4'd14:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/btbm_if.sv]
`timescale 1ns / 1ps
// Interfaces: track input channel and pair result channel.
interface btbm_trk_if;
	logic               valid;
	logic               ready;
	logic               first_of_event;
	logic [7:0]         hit_count;
	logic [15:0]        start_radius;
	logic [15:0]        start_azimuth;
	logic signed [15:0] start_z;
	logic [15:0]        direction;
	logic [15:0]        transverse_momentum;
	logic signed [15:0] dip_tangent;

	modport source (output valid, first_of_event, hit_count, start_radius, start_azimuth,
		start_z, direction, transverse_momentum, dip_tangent, input ready);
	modport sink (input valid, first_of_event, hit_count, start_radius, start_azimuth,
		start_z, direction, transverse_momentum, dip_tangent, output ready);
endinterface

interface btbm_pair_if;
	logic               valid;
	logic               ready;
	logic [5:0]         earlier_index;
	logic [5:0]         later_index;
	logic signed [18:0] momentum_difference;
	logic [17:0]        earlier_momentum;
	logic               last_match;

	modport source (output valid, earlier_index, later_index, momentum_difference,
		earlier_momentum, last_match, input ready);
	modport sink (input valid, earlier_index, later_index, momentum_difference,
		earlier_momentum, last_match, output ready);
endinterface

[rtl/core/btbm_cordic.sv]
`timescale 1ns / 1ps
// Iterative CORDIC rotation: start point x and y from radius and azimuth.
module btbm_cordic (
	input  logic                      clk,
	input  logic                      arst_n,
	input  btbm_pkg::unit_ctl_t       ctl,
	output btbm_pkg::unit_sts_t       sts,
	input  logic [15:0]               radius,
	input  logic [15:0]               azimuth,
	output logic signed [17:0]        x,
	output logic signed [17:0]        y
);
	import btbm_pkg::*;

	logic                        busy_q;
	logic [3:0]                  it_q;
	logic signed [CORDIC_W-1:0]  x_q, y_q;
	logic signed [ANGLE_Z_W-1:0] z_q;

	logic signed [CORDIC_W-1:0]  x_init, dx, dy, x_rnd, y_rnd;
	logic signed [ANGLE_Z_W-1:0] z_init, z_ext, atan_ext;

	always_comb begin
		x_init = signed'({4'b0, 32'(radius) * 32'(INV_GAIN)});
		z_ext = ANGLE_Z_W'(signed'(azimuth));
		z_init = z_ext;
		// Fold the angle into the right half plane first.
		if (z_ext > 18'sd16384) begin
			x_init = -x_init;
			z_init = z_ext - 18'sd32768;
		end else if (z_ext < -18'sd16384) begin
			x_init = -x_init;
			z_init = z_ext + 18'sd32768;
		end
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		atan_ext = signed'({4'b0, atan_turn(it_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			it_q <= '0;
		end else if (busy_q) begin
			it_q <= it_q + 4'd1;
			if (it_q == 4'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x_init;
			y_q <= '0;
			z_q <= z_init;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_ext;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_ext;
			end
		end
	end

	assign sts.busy = busy_q;

	// Round to nearest with ties up, then clamp to the 18-bit range.
	always_comb begin
		x_rnd = (x_q + 36'sd32768) >>> 16;
		y_rnd = (y_q + 36'sd32768) >>> 16;
		if (x_rnd > 36'sd131071) x = 18'sd131071;
		else if (x_rnd < -36'sd131071) x = -18'sd131071;
		else x = x_rnd[17:0];
		if (y_rnd > 36'sd131071) y = 18'sd131071;
		else if (y_rnd < -36'sd131071) y = -18'sd131071;
		else y = y_rnd[17:0];
	end

endmodule

[rtl/core/btbm_momentum.sv]
`timescale 1ns / 1ps
// Total momentum: two multiply stages, then a bit-serial square root.
module btbm_momentum (
	input  logic                clk,
	input  logic                arst_n,
	input  btbm_pkg::unit_ctl_t ctl,
	output btbm_pkg::unit_sts_t sts,
	input  logic [15:0]         pt,
	input  logic signed [15:0]  tanl,
	output logic [17:0]         p
);
	import btbm_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_ROOT} phase_t;

	phase_t             phase_q;
	logic [4:0]         cnt_q;
	logic [31:0]        pt2_s1;
	logic [31:0]        fac_s1;
	logic [ROOT_W-1:0]  v_q, res_q, bit_q;
	logic [63:0]        prod;
	logic [31:0]        t2;
	logic [ROOT_W-1:0]  trial;

	always_comb begin
		t2 = 32'(tanl * tanl);
		prod = 64'(pt2_s1) * 64'(fac_s1);
		trial = res_q + bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (ctl.start) phase_q <= PH_MUL;
				end
				PH_MUL: begin
					phase_q <= PH_ROOT;
					cnt_q <= '0;
				end
				PH_ROOT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ROOT_STEPS - 1)) phase_q <= PH_IDLE;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			pt2_s1 <= 32'(pt) * 32'(pt);
			fac_s1 <= 32'h0100_0000 + t2;
		end
		if (phase_q == PH_MUL) begin
			v_q <= prod[63:24];
			res_q <= '0;
			bit_q <= ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
		end else if (phase_q == PH_ROOT) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign sts.busy = (phase_q != PH_IDLE) || ctl.start;
	assign p = (res_q > ROOT_W'(P_MAX)) ? P_MAX : res_q[17:0];

endmodule

[rtl/core/btbm_cell.sv]
`timescale 1ns / 1ps
// One ring cell: holds a stored track and takes its neighbor's track on a shift.
module btbm_cell (
	input  logic             clk,
	input  logic             shift,
	input  btbm_pkg::track_t d,
	output btbm_pkg::track_t q
);
	import btbm_pkg::*;

	track_t trk_q;

	always_ff @(posedge clk) begin
		if (shift) trk_q <= d;
	end

	assign q = trk_q;

endmodule

[rtl/core/back_to_back_track_pair_matcher.sv]
`timescale 1ns / 1ps
// Top level: track front end, ring of track cells, pair compare and result register.
//
//  channel  | role   | carries
//  ---------+--------+-----------------------------------------------------------
//  trk      | sink   | one fitted track per transfer
//  pair     | source | one matched pair per transfer, last_match on the final one
//  apb      | slave  | min_hits, angle_window, x_window, y_window, z_window
//
// A track passes the front end and then the scan; pair channel stalls can hold the scan.
// The front end is set by the 20-step square root, which runs beside the 16-step
// CORDIC; the scan is one full turn of the ring, one cell past the compare per cycle
// unless the ring is frozen. A track dropped for a full store leaves the block idle.
// Reset clears the control state and the configuration registers; the ring contents are not cleared.
// A stalled result freezes the ring when a match waits behind it and another is found.
module back_to_back_track_pair_matcher #(
	parameter int MAX_TRACKS = btbm_pkg::DEFAULT_MAX_TRACKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [btbm_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	btbm_trk_if.sink                         trk,
	btbm_pair_if.source                      pair
);
	import btbm_pkg::*;

	localparam int CNT_W = $clog2(MAX_TRACKS + 1);
	localparam int K_W = $clog2(MAX_TRACKS);

	typedef enum logic [1:0] {S_IDLE, S_PREP, S_SCAN, S_FLUSH} state_t;

	// Configuration registers.
	logic [7:0]  min_hits_q;
	logic [15:0] angle_window_q, x_window_q, y_window_q, z_window_q;
	reg_index_t  reg_idx;

	assign reg_idx = reg_index_t'(paddr[4:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hits_q <= MIN_HITS_RST;
			angle_window_q <= ANGLE_WINDOW_RST;
			x_window_q <= X_WINDOW_RST;
			y_window_q <= Y_WINDOW_RST;
			z_window_q <= Z_WINDOW_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MIN_HITS:     min_hits_q <= pwdata[7:0];
				REG_ANGLE_WINDOW: angle_window_q <= pwdata[15:0];
				REG_X_WINDOW:     x_window_q <= pwdata[15:0];
				REG_Y_WINDOW:     y_window_q <= pwdata[15:0];
				REG_Z_WINDOW:     z_window_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_HITS:     prdata = {24'b0, min_hits_q};
			REG_ANGLE_WINDOW: prdata = {16'b0, angle_window_q};
			REG_X_WINDOW:     prdata = {16'b0, x_window_q};
			REG_Y_WINDOW:     prdata = {16'b0, y_window_q};
			REG_Z_WINDOW:     prdata = {16'b0, z_window_q};
			default:          prdata = '0;
		endcase
	end

	// Control state.
	state_t             state_q;
	logic [CNT_W-1:0]   count_q, cur_q;
	logic [K_W-1:0]     k_q;
	logic               qual_q;
	logic signed [15:0] z_q;
	logic [15:0]        dir_q;
	logic [5:0]         nmatch_q;
	logic               pend_q;
	logic [5:0]         pend_idx_q;
	logic signed [18:0] pend_dp_q;
	logic [17:0]        pend_p_q;
	logic               out_valid_q;
	logic [5:0]         out_earlier_q, out_later_q;
	logic signed [18:0] out_dp_q;
	logic [17:0]        out_p_q;
	logic               out_last_q;

	logic               accept;
	logic [CNT_W-1:0]   eff_count;
	logic               take;
	unit_ctl_t          unit_ctl;
	unit_sts_t          cordic_sts, mom_sts;
	logic signed [17:0] new_x, new_y;
	logic [17:0]        new_p;

	assign trk.ready = (state_q == S_IDLE);
	assign accept = trk.valid && trk.ready;
	assign eff_count = trk.first_of_event ? '0 : count_q;
	assign take = accept && (eff_count < CNT_W'(MAX_TRACKS));
	assign unit_ctl.start = take;

	btbm_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (unit_ctl),
		.sts     (cordic_sts),
		.radius  (trk.start_radius),
		.azimuth (trk.start_azimuth),
		.x       (new_x),
		.y       (new_y)
	);

	btbm_momentum u_momentum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (unit_ctl),
		.sts    (mom_sts),
		.pt     (trk.transverse_momentum),
		.tanl   (trk.dip_tangent),
		.p      (new_p)
	);

	// Ring of cells; cell 0 is the head that meets the compare logic.
	track_t ring_q [MAX_TRACKS];
	track_t ring_d [MAX_TRACKS];
	track_t new_trk, head;
	logic   shift;

	always_comb begin
		new_trk.x = new_x;
		new_trk.y = new_y;
		new_trk.z = z_q;
		new_trk.dir = dir_q;
		new_trk.p = new_p;
		new_trk.qual = qual_q;
		head = ring_q[0];
	end

	for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_ring
		if (i == MAX_TRACKS - 1) begin : g_tail
			// The new track drops in where its own index passes the tail.
			assign ring_d[i] = (CNT_W'(k_q) == cur_q) ? new_trk : ring_q[0];
		end else begin : g_body
			assign ring_d[i] = ring_q[i + 1];
		end
		btbm_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (ring_d[i]),
			.q     (ring_q[i])
		);
	end

	// Pair test between the head cell and the current track.
	logic signed [16:0] dir_diff;
	logic signed [18:0] dd, lo, hi;
	logic signed [18:0] xd, yd;
	logic signed [16:0] zd;
	logic [18:0]        xa, ya;
	logic [16:0]        za;
	logic               cand, match, out_free, adv;
	logic               push_pend;

	always_comb begin
		dir_diff = signed'({1'b0, head.dir}) - signed'({1'b0, dir_q});
		dd = (dir_diff < 0) ? 19'(-dir_diff) : 19'(dir_diff);
		lo = 19'sd32768 - signed'({3'b0, angle_window_q});
		hi = 19'sd32768 + signed'({3'b0, angle_window_q});
		xd = 19'(head.x) - 19'(new_x);
		yd = 19'(head.y) - 19'(new_y);
		zd = 17'(head.z) - 17'(z_q);
		xa = (xd < 0) ? 19'(-xd) : 19'(xd);
		ya = (yd < 0) ? 19'(-yd) : 19'(yd);
		za = (zd < 0) ? 17'(-zd) : 17'(zd);
		cand = (state_q == S_SCAN) && qual_q && head.qual && (CNT_W'(k_q) < cur_q)
			&& (nmatch_q != MAX_RESULTS);
		match = cand && (lo < dd) && (dd < hi) && (xa < 19'(x_window_q))
			&& (ya < 19'(y_window_q)) && (za < 17'(z_window_q));
		out_free = !out_valid_q || pair.ready;
		// A new match can only be taken if the waiting one can move to the output.
		adv = (state_q == S_SCAN) && !(match && pend_q && !out_free);
		shift = adv;
	end

	// The waiting match moves to the output when a newer one replaces it or the scan ends.
	assign push_pend = ((state_q == S_SCAN) && adv && match && pend_q)
		|| ((state_q == S_FLUSH) && pend_q && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cur_q <= '0;
			k_q <= '0;
			nmatch_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_pend) out_valid_q <= 1'b1;
			else if (pair.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (take) begin
							cur_q <= eff_count;
							count_q <= eff_count + CNT_W'(1);
							state_q <= S_PREP;
						end else begin
							count_q <= eff_count;
						end
					end
				end
				S_PREP: begin
					if (!cordic_sts.busy && !mom_sts.busy) begin
						k_q <= '0;
						nmatch_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (adv) begin
						if (k_q == K_W'(MAX_TRACKS - 1)) begin
							k_q <= '0;
							state_q <= S_FLUSH;
						end else begin
							k_q <= k_q + K_W'(1);
						end
						if (match) begin
							nmatch_q <= nmatch_q + 6'd1;
							pend_q <= 1'b1;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			qual_q <= (trk.hit_count >= min_hits_q);
			z_q <= trk.start_z;
			dir_q <= trk.direction;
		end
		if (push_pend) begin
			out_earlier_q <= pend_idx_q;
			out_later_q <= 6'(cur_q);
			out_dp_q <= pend_dp_q;
			out_p_q <= pend_p_q;
			out_last_q <= (state_q == S_FLUSH);
		end
		if (adv && match) begin
			pend_idx_q <= 6'(k_q);
			pend_dp_q <= signed'({1'b0, head.p}) - signed'({1'b0, new_p});
			pend_p_q <= head.p;
		end
	end

	assign pair.valid = out_valid_q;
	assign pair.earlier_index = out_earlier_q;
	assign pair.later_index = out_later_q;
	assign pair.momentum_difference = out_dp_q;
	assign pair.earlier_momentum = out_p_q;
	assign pair.last_match = out_last_q;

	// A waiting match exists only while a track is being scanned or flushed.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == S_SCAN || state_q == S_FLUSH))
		else $error("pending match outside of a scan");

	// The event store never counts past its size.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TRACKS))
		else $error("track count beyond store size");

	// A new track is taken only when the CORDIC unit is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		trk.ready |-> !cordic_sts.busy)
		else $error("track taken while CORDIC busy");

	// The scan index wraps back to zero when the ring is realigned.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> (k_q == '0))
		else $error("ring not realigned after scan");

endmodule
